/* src/assert_macros.svh */
// Assertion macros shared by the stack buffer RTL.
// Uses the clk and arst_n names of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define KSS_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

`define KSS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`else

`define KSS_ASSERT(lbl, expr, msg)

`define KSS_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

/* src/kss_pkg.sv */
// Types, constants and helpers for the shared stack buffer.
// No dependencies.
`timescale 1ns / 1ps

package kss_pkg;

	localparam int DEPTH      = 256;
	localparam int STACKS     = 8;
	localparam int ELEM_WIDTH = 32;

	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SID_W  = $clog2(STACKS);

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [SID_W-1:0]  sid_t;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		addr_t base;
		cnt_t  cnt;
	} desc_t;

	typedef struct packed {
		logic  we;
		sid_t  addr;
		desc_t data;
	} desc_wr_t;

	function automatic addr_t init_base(sid_t idx);
		return ADDR_W'((int'(idx) * DEPTH) / STACKS);
	endfunction

	function automatic sid_t next_sid(sid_t s);
		return (s == SID_W'(STACKS - 1)) ? '0 : s + 1'b1;
	endfunction

endpackage

/* src/kss_in_if.sv */
// Command channel of the shared stack buffer: valid/ready plus one operation.
// No dependencies.
`timescale 1ns / 1ps

interface kss_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [2:0]  stack_id;
	logic [31:0] value;

	modport source(output valid, output mode, output stack_id, output value, input ready);
	modport sink(input valid, input mode, input stack_id, input value, output ready);
endinterface

/* src/kss_out_if.sv */
// Result channel of the shared stack buffer: valid/ready plus status and counts.
// No dependencies.
`timescale 1ns / 1ps

interface kss_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [8:0] stack_count;
	logic [8:0] total_count;

	modport source(output valid, output status, output stack_count, output total_count,
		input ready);
	modport sink(input valid, input status, input stack_count, input total_count,
		output ready);
endinterface

/* src/kss_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kss_ram #(
	parameter int WIDTH   = 8,
	parameter int ENTRIES = 16,
	localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [ENTRIES];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* src/kss_desc.sv */
// Stack descriptor table (base, count per stack) in a small RAM.
// Valid bits stand in for the evenly spaced reset layout. Uses kss_pkg, kss_ram.
`timescale 1ns / 1ps

module kss_desc import kss_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  sid_t     raddr,
	input  desc_wr_t wr,
	output desc_t    rdata
);
	logic [STACKS-1:0]      valid_q;
	logic                   rd_valid_s1;
	sid_t                   rd_idx_s1;
	logic [$bits(desc_t)-1:0] ram_rdata;

	kss_ram #(
		.WIDTH  ($bits(desc_t)),
		.ENTRIES(STACKS)
	) u_ram (
		.clk  (clk),
		.we   (wr.we),
		.waddr(wr.addr),
		.wdata(wr.data),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			if (wr.we) begin
				valid_q[wr.addr] <= 1'b1;
			end
			rd_valid_s1 <= valid_q[raddr];
			rd_idx_s1   <= raddr;
		end
	end

	always_comb begin
		if (rd_valid_s1) begin
			rdata = desc_t'(ram_rdata);
		end else begin
			rdata.base = init_base(rd_idx_s1);
			rdata.cnt  = '0;
		end
	end
endmodule

/* src/k_stacks_shared_buffer.sv */
// Several LIFO stacks sharing one circular element RAM. An item is a push or a pop on
// one stack and yields one result with a status and the stack and total counts. Pops,
// refused pushes and empty pops go from acceptance through S_RDK to S_FIN; a command
// with an out-of-range stack id goes straight to S_FIN. A push scans the descriptor
// RAM one stack per cycle for the chain of packed neighbors that must move up one slot,
// then moves their elements one per cycle through the element RAM: it scans 1 to STACKS
// stacks and moves 0 to DEPTH-1 elements, and the element RAM copy loop sets the worst
// case. One item is in work at a time; the next item is taken the cycle after the
// result is registered, and a finished result waits in an output register while it is.
// No clearing pass after reset.
// Uses kss_pkg, kss_in_if, kss_out_if, kss_ram, kss_desc, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module k_stacks_shared_buffer import kss_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	kss_in_if.sink    cmd,
	kss_out_if.source res
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_RDK,
		S_SCAN,
		S_COPY,
		S_FIN
	} state_t;

	state_t                state_q;
	mode_t                 mode_q;
	sid_t                  k_q;
	logic [ELEM_WIDTH-1:0] value_q;
	addr_t                 base_k_q;
	cnt_t                  cnt_k_q;
	sid_t                  j_q;
	sid_t                  steps_q;
	addr_t                 prev_top_q;
	addr_t                 copy_ptr_q;
	addr_t                 copy_left_q;
	logic                  wr_pend_s1;
	addr_t                 wr_addr_s1;
	logic                  do_push_q;
	logic                  do_pop_q;
	status_t               status_q;
	cnt_t                  total_q;
	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [8:0]            out_stack_count_q;
	logic [8:0]            out_total_count_q;

	sid_t                  desc_raddr;
	desc_wr_t              desc_wr;
	desc_t                 desc_rd;

	logic                  e_we;
	addr_t                 e_waddr;
	logic [ELEM_WIDTH-1:0] e_wdata;
	addr_t                 e_raddr;
	logic [ELEM_WIDTH-1:0] e_rdata;

	addr_t top_k;
	addr_t d_top;
	addr_t end_top;
	logic  in_chain;
	logic  scan_end;
	logic  accept;
	logic  oor;
	logic  fire_fin;
	cnt_t  new_cnt;
	cnt_t  new_total;

	kss_desc u_desc (
		.clk   (clk),
		.arst_n(arst_n),
		.raddr (desc_raddr),
		.wr    (desc_wr),
		.rdata (desc_rd)
	);

	kss_ram #(
		.WIDTH  (ELEM_WIDTH),
		.ENTRIES(DEPTH)
	) u_elem (
		.clk  (clk),
		.we   (e_we),
		.waddr(e_waddr),
		.wdata(e_wdata),
		.raddr(e_raddr),
		.rdata(e_rdata)
	);

	assign cmd.ready       = (state_q == S_IDLE);
	assign res.valid       = out_valid_q;
	assign res.status      = out_status_q;
	assign res.stack_count = out_stack_count_q;
	assign res.total_count = out_total_count_q;

	always_comb begin
		accept   = cmd.valid && (state_q == S_IDLE);
		oor      = (int'(cmd.stack_id) >= STACKS);
		top_k    = base_k_q + addr_t'(cnt_k_q);
		d_top    = desc_rd.base + addr_t'(desc_rd.cnt);
		in_chain = (prev_top_q == desc_rd.base);
		scan_end = !in_chain || (steps_q == SID_W'(STACKS - 1));
		end_top  = in_chain ? d_top : prev_top_q;
		fire_fin = (state_q == S_FIN) && (!out_valid_q || res.ready);

		new_cnt   = cnt_k_q;
		new_total = total_q;
		if (do_push_q) begin
			new_cnt   = cnt_k_q + 1'b1;
			new_total = total_q + 1'b1;
		end else if (do_pop_q) begin
			new_cnt   = cnt_k_q - 1'b1;
			new_total = total_q - 1'b1;
		end

		case (state_q)
			S_IDLE:  desc_raddr = SID_W'(cmd.stack_id);
			S_RDK:   desc_raddr = next_sid(k_q);
			S_SCAN:  desc_raddr = next_sid(j_q);
			default: desc_raddr = k_q;
		endcase

		desc_wr = '0;
		if (state_q == S_SCAN && in_chain) begin
			desc_wr.we        = 1'b1;
			desc_wr.addr      = j_q;
			desc_wr.data.base = desc_rd.base + 1'b1;
			desc_wr.data.cnt  = desc_rd.cnt;
		end else if (fire_fin && (do_push_q || do_pop_q)) begin
			desc_wr.we        = 1'b1;
			desc_wr.addr      = k_q;
			desc_wr.data.base = base_k_q;
			desc_wr.data.cnt  = new_cnt;
		end

		e_raddr = copy_ptr_q - 1'b1;
		e_we    = 1'b0;
		e_waddr = wr_addr_s1;
		e_wdata = e_rdata;
		if (wr_pend_s1) begin
			e_we = 1'b1;
		end else if (fire_fin && do_push_q) begin
			e_we    = 1'b1;
			e_waddr = top_k;
			e_wdata = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			wr_pend_s1  <= 1'b0;
			do_push_q   <= 1'b0;
			do_pop_q    <= 1'b0;
		end else begin
			wr_pend_s1 <= 1'b0;
			if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q    <= mode_t'(cmd.mode);
						k_q       <= SID_W'(cmd.stack_id);
						value_q   <= ELEM_WIDTH'(cmd.value);
						do_push_q <= 1'b0;
						do_pop_q  <= 1'b0;
						status_q  <= ST_DONE;
						if (oor) begin
							cnt_k_q <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RDK;
						end
					end
				end
				S_RDK: begin
					base_k_q <= desc_rd.base;
					cnt_k_q  <= desc_rd.cnt;
					if (mode_q == MODE_POP) begin
						if (desc_rd.cnt == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							do_pop_q <= 1'b1;
						end
						state_q <= S_FIN;
					end else if (total_q == CNT_W'(DEPTH)) begin
						status_q <= ST_FULL;
						state_q  <= S_FIN;
					end else begin
						do_push_q  <= 1'b1;
						prev_top_q <= d_top;
						j_q        <= next_sid(k_q);
						steps_q    <= '0;
						state_q    <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (in_chain) begin
						prev_top_q <= d_top;
						j_q        <= next_sid(j_q);
						steps_q    <= steps_q + 1'b1;
					end
					if (scan_end) begin
						copy_ptr_q  <= end_top;
						copy_left_q <= end_top - top_k;
						state_q     <= S_COPY;
					end
				end
				S_COPY: begin
					if (copy_left_q != '0) begin
						wr_pend_s1  <= 1'b1;
						wr_addr_s1  <= copy_ptr_q;
						copy_ptr_q  <= copy_ptr_q - 1'b1;
						copy_left_q <= copy_left_q - 1'b1;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fire_fin) begin
						out_valid_q       <= 1'b1;
						out_status_q      <= status_q;
						out_stack_count_q <= 9'(new_cnt);
						out_total_count_q <= 9'(new_total);
						total_q           <= new_total;
						do_push_q         <= 1'b0;
						do_pop_q          <= 1'b0;
						state_q           <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`KSS_ASSERT(a_total_range, total_q <= CNT_W'(DEPTH), "total count beyond depth")
	`KSS_ASSERT_IMP(a_copy_hazard, wr_pend_s1, wr_addr_s1 != e_raddr, "copy read hits write")
	`KSS_ASSERT_IMP(a_fin_drained, state_q == S_FIN, !wr_pend_s1, "copy write pending at finish")
	`KSS_ASSERT_IMP(a_push_room, state_q == S_FIN && do_push_q, total_q < CNT_W'(DEPTH), "push full")
	`KSS_ASSERT_IMP(a_desc_rw, state_q == S_SCAN && desc_wr.we, desc_wr.addr != desc_raddr, "desc rw")
endmodule
